@@ rtl/core/dtq_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dtq_pkg: shared types and constants of the deadline timeout queue
// Request codes, status codes, default sizes and the front-to-back command.
// ----------------------------------------------------------------------------
package dtq_pkg;

	localparam int NumSlotsDefault   = 16;
	localparam int TimeWidthDefault  = 32;
	localparam int DelayWidthDefault = 16;
	localparam int SlotWidth         = 4;
	localparam int ReqWidth          = 2;
	localparam int StatusWidth       = 2;
	localparam int OutTimeWidth      = 32;
	localparam int OutDelayWidth     = 16;
	localparam int MaxResults        = 16;

	typedef enum logic [ReqWidth-1:0] {
		REQ_ADD    = 2'd0,
		REQ_CANCEL = 2'd1,
		REQ_RESET  = 2'd2,
		REQ_TICK   = 2'd3
	} req_t;

	typedef enum logic [StatusWidth-1:0] {
		ST_OK        = 2'd0,
		ST_ARMED     = 2'd1,
		ST_NOT_ARMED = 2'd2
	} status_t;

	typedef struct packed {
		req_t                    req;
		logic [SlotWidth-1:0]    slot;
		logic [OutDelayWidth-1:0] delay;
		logic [OutTimeWidth-1:0] now_time;
	} cmd_t;

endpackage
`default_nettype wire

@@ rtl/core/dtq_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dtq_req_if / dtq_rsp_if: valid-ready channels of the timeout queue
// Request and result words with source and sink modports.
// ----------------------------------------------------------------------------
interface dtq_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [3:0]  slot;
	logic [15:0] delay;
	logic [31:0] now_time;
	modport source (output valid, req_type, slot, delay, now_time, input ready);
	modport sink (input valid, req_type, slot, delay, now_time, output ready);
endinterface

interface dtq_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic        expired_valid;
	logic [3:0]  expired_slot;
	logic        last;
	logic        queue_empty;
	logic [31:0] next_deadline;
	modport source (output valid, status, expired_valid, expired_slot, last,
		queue_empty, next_deadline, input ready);
	modport sink (input valid, status, expired_valid, expired_slot, last,
		queue_empty, next_deadline, output ready);
endinterface
`default_nettype wire

@@ rtl/core/deadline_timeout_queue_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// deadline_timeout_queue_unit: sorted timer queue, top level
//   channel  dir  words
//   req      in   add, cancel, reset, tick requests
//   rsp      out  status and expired slots, last marks the final word
// An add, cancel or reset walks the slot order in the back end one entry a
// cycle. A tick removes each due head in the same way, then sends one result
// word per expired slot, or a single word if none expired. A stalled result
// word holds the back end. Reset clears all state but the command queue words.
// A two-entry queue lets intake run while results stall.
// ----------------------------------------------------------------------------
module deadline_timeout_queue_unit #(
	parameter int NUM_SLOTS   = dtq_pkg::NumSlotsDefault,
	parameter int TIME_WIDTH  = dtq_pkg::TimeWidthDefault,
	parameter int DELAY_WIDTH = dtq_pkg::DelayWidthDefault
) (
	input wire logic  clk,
	input wire logic  arst_n,
	dtq_req_if.sink   req,
	dtq_rsp_if.source rsp
);
	dtq_pkg::cmd_t cmd;
	logic          cmd_valid, cmd_pop;

	dtq_front u_front (
		.clk, .arst_n, .req, .cmd, .cmd_valid, .cmd_pop
	);

	dtq_back #(
		.NUM_SLOTS(NUM_SLOTS), .TIME_WIDTH(TIME_WIDTH), .DELAY_WIDTH(DELAY_WIDTH)
	) u_back (
		.clk, .arst_n, .cmd, .cmd_valid, .cmd_pop, .rsp
	);
endmodule
`default_nettype wire

@@ rtl/core/dtq_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dtq_front: request intake
// Accept request words and push them into a two-entry command queue.
// ----------------------------------------------------------------------------
module dtq_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	dtq_req_if.sink            req,
	output dtq_pkg::cmd_t      cmd,
	output logic               cmd_valid,
	input  wire logic          cmd_pop
);
	dtq_pkg::cmd_t fifo_q [2];
	logic          wr_q, rd_q;
	logic [1:0]    cnt_q;
	logic          push;

	assign req.ready = (cnt_q != 2'd2);
	assign push      = req.valid && req.ready;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = fifo_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (cmd_pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, cmd_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_q] <= '{req: dtq_pkg::req_t'(req.req_type), slot: req.slot,
				delay: req.delay, now_time: req.now_time};
		end
	end
endmodule
`default_nettype wire

@@ rtl/core/dtq_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dtq_back: timeout queue engine
// Keep the deadline-sorted slot order, insert and remove one entry a cycle,
// expire due heads on a tick, send one word per expired slot (one if none).
// ----------------------------------------------------------------------------
module dtq_back #(
	parameter int NUM_SLOTS   = dtq_pkg::NumSlotsDefault,
	parameter int TIME_WIDTH  = dtq_pkg::TimeWidthDefault,
	parameter int DELAY_WIDTH = dtq_pkg::DelayWidthDefault
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  dtq_pkg::cmd_t cmd,
	input  wire logic     cmd_valid,
	output logic          cmd_pop,
	dtq_rsp_if.source     rsp
);
	localparam int IW = $clog2(NUM_SLOTS);
	localparam int CW = $clog2(NUM_SLOTS + 1);
	localparam int SW = dtq_pkg::SlotWidth;
	localparam int MR = dtq_pkg::MaxResults;
	localparam int EW = $clog2(MR);
	localparam int RW = $clog2(MR + 1);

	typedef enum logic [2:0] {
		S_IDLE, S_FIND, S_REMOVE, S_SCAN, S_SHIFT, S_TICK, S_OUT
	} state_t;

	state_t                 state_q;
	logic [NUM_SLOTS-1:0]   armed_q;
	logic [TIME_WIDTH-1:0]  dl_q  [NUM_SLOTS];
	logic [DELAY_WIDTH-1:0] dly_q [NUM_SLOTS];
	logic [IW-1:0]          ord_q [NUM_SLOTS];
	logic [SW-1:0]          exp_q [MR];
	logic [CW-1:0]          cnt_q;
	logic [CW-1:0]          idx_q;
	logic [IW-1:0]          s_q;
	logic [TIME_WIDTH-1:0]  t_q;
	logic                   insert_q;
	logic [RW-1:0]          nexp_q;
	logic [RW-1:0]          oidx_q;
	logic [1:0]             status_q;
	logic                   ev_q, last_q;
	logic [SW-1:0]          es_q;

	logic [TIME_WIDTH-1:0]  now_w, dl_new, diff_d, head_dl;
	logic [IW-1:0]          idx_i, head, slot_i;
	logic                   in_range;
	logic [TIME_WIDTH-1:0]  nd_w;

	assign now_w    = TIME_WIDTH'(cmd.now_time);
	assign idx_i    = idx_q[IW-1:0];
	assign slot_i   = IW'(cmd.slot);
	assign in_range = ({{(32-SW){1'b0}}, cmd.slot} < 32'(NUM_SLOTS));
	assign dl_new   = t_q;
	assign diff_d   = t_q - dl_q[ord_q[idx_i]];
	assign head     = ord_q[0];
	assign head_dl  = now_w - dl_q[head];
	assign nd_w     = (cnt_q == '0) ? '0 : dl_q[ord_q[0]];

	assign cmd_pop           = (state_q == S_OUT) && rsp.ready && last_q;
	assign rsp.valid         = (state_q == S_OUT);
	assign rsp.status        = status_q;
	assign rsp.expired_valid = ev_q;
	assign rsp.expired_slot  = es_q;
	assign rsp.last          = last_q;
	assign rsp.queue_empty   = (cnt_q == '0);
	assign rsp.next_deadline = 32'(nd_w);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			armed_q  <= '0;
			cnt_q    <= '0;
			dl_q     <= '{default: '0};
			dly_q    <= '{default: '0};
			ord_q    <= '{default: '0};
			exp_q    <= '{default: '0};
			idx_q    <= '0;
			s_q      <= '0;
			t_q      <= '0;
			insert_q <= 1'b0;
			nexp_q   <= '0;
			oidx_q   <= '0;
			status_q <= dtq_pkg::ST_OK;
			ev_q     <= 1'b0;
			last_q   <= 1'b0;
			es_q     <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: if (cmd_valid) begin
					status_q <= dtq_pkg::ST_OK;
					ev_q     <= 1'b0;
					es_q     <= '0;
					last_q   <= 1'b1;
					idx_q    <= '0;
					nexp_q   <= '0;
					s_q      <= slot_i;
					insert_q <= 1'b0;
					if (cmd.req == dtq_pkg::REQ_TICK) begin
						state_q <= S_TICK;
					end else if (!in_range) begin
						status_q <= dtq_pkg::ST_NOT_ARMED;
						state_q  <= S_OUT;
					end else if (cmd.req == dtq_pkg::REQ_ADD) begin
						if (armed_q[slot_i]) begin
							status_q <= dtq_pkg::ST_ARMED;
							state_q  <= S_OUT;
						end else begin
							dly_q[slot_i] <= DELAY_WIDTH'(cmd.delay);
							t_q     <= now_w + TIME_WIDTH'(DELAY_WIDTH'(cmd.delay));
							armed_q[slot_i] <= 1'b1;
							state_q <= S_SCAN;
						end
					end else if (!armed_q[slot_i]) begin
						status_q <= dtq_pkg::ST_NOT_ARMED;
						state_q  <= S_OUT;
					end else begin
						if (cmd.req == dtq_pkg::REQ_CANCEL)
							armed_q[slot_i] <= 1'b0;
						else begin
							insert_q <= 1'b1;
							t_q <= now_w + TIME_WIDTH'(dly_q[slot_i]);
						end
						state_q <= S_FIND;
					end
				end
				S_FIND: begin
					if (ord_q[idx_i] == s_q) state_q <= S_REMOVE;
					else idx_q <= idx_q + 1'b1;
				end
				S_REMOVE: begin
					if (idx_q + 1'b1 < cnt_q) begin
						ord_q[idx_i] <= ord_q[IW'(idx_q + 1'b1)];
						idx_q <= idx_q + 1'b1;
					end else begin
						cnt_q <= cnt_q - 1'b1;
						idx_q <= '0;
						if (insert_q) state_q <= S_SCAN;
						else if (cmd.req == dtq_pkg::REQ_TICK) state_q <= S_TICK;
						else state_q <= S_OUT;
					end
				end
				S_SCAN: begin
					if (idx_q < cnt_q && !diff_d[TIME_WIDTH-1]) begin
						idx_q <= idx_q + 1'b1;
					end else begin
						dl_q[s_q] <= dl_new;
						idx_q     <= cnt_q;
						state_q   <= S_SHIFT;
						t_q       <= TIME_WIDTH'(idx_q);
					end
				end
				S_SHIFT: begin
					if (idx_q > CW'(t_q)) begin
						ord_q[idx_i] <= ord_q[IW'(idx_q - 1'b1)];
						idx_q <= idx_q - 1'b1;
					end else begin
						ord_q[idx_i] <= s_q;
						cnt_q   <= cnt_q + 1'b1;
						state_q <= S_OUT;
					end
				end
				S_TICK: begin
					if (cnt_q != '0 && !head_dl[TIME_WIDTH-1] && nexp_q < RW'(MR)) begin
						exp_q[nexp_q[EW-1:0]] <= SW'(head);
						idx_q         <= '0;
						armed_q[head] <= 1'b0;
						nexp_q        <= nexp_q + 1'b1;
						state_q       <= S_REMOVE;
					end else begin
						if (nexp_q != '0) begin
							ev_q   <= 1'b1;
							es_q   <= exp_q[0];
							last_q <= (nexp_q == RW'(1));
						end
						oidx_q  <= RW'(1);
						state_q <= S_OUT;
					end
				end
				S_OUT: if (rsp.ready) begin
					if (last_q) begin
						state_q <= S_IDLE;
					end else begin
						es_q   <= exp_q[oidx_q[EW-1:0]];
						last_q <= (oidx_q + 1'b1 == nexp_q);
						oidx_q <= oidx_q + 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire
